@@ hdl/sfla_pkg.sv @@
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared sizes, codes and command types of the slot table allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

    // Table and free stack depths
    localparam int SLOT_COUNT       = 1024;
    localparam int FREE_STACK_DEPTH = 1024;

    // Field and index widths
    localparam int SLOT_W   = 10;
    localparam int VALUE_W  = 64;
    localparam int HW_W     = $clog2(SLOT_COUNT + 1);
    localparam int FC_W     = $clog2(FREE_STACK_DEPTH + 1);
    localparam int STK_AW   = $clog2(FREE_STACK_DEPTH);

    localparam logic [HW_W-1:0] SLOT_COUNT_HW  = HW_W'(SLOT_COUNT);
    localparam logic [FC_W-1:0] STACK_DEPTH_FC = FC_W'(FREE_STACK_DEPTH);

    // Null marker: most negative 64-bit value
    localparam logic [VALUE_W-1:0] NULL_MARK = {1'b1, {(VALUE_W-1){1'b0}}};

    // Request codes
    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_GET  = 2'd2
    } action_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_STACK = 2'd3
    } status_t;

    // Controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch request, launch memory reads
        logic exec;     // commit state update, load result register
    } sfla_cmd_t;

endpackage

@@ hdl/sfla_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfla_ctrl
// Sequencer: accepts a request, runs the execute cycle, owns the result valid.
// ----------------------------------------------------------------------------
module sfla_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sfla_pkg::sfla_cmd_t  cmd
);

    sfla_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    // State and result valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfla_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        logic out_free;
        out_free       = !out_valid_reg || !out_stall;
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        // a beat taken from the result register frees it
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            sfla_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sfla_pkg::S_EXEC;
                end
            end
            sfla_pkg::S_EXEC:
            begin
                // hold the request until the result register can take it
                if (out_free)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = sfla_pkg::S_IDLE;
                end
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hdl/sfla_datapath.sv @@
// ----------------------------------------------------------------------------
// sfla_datapath
// Slot value memory, free stack memory, counters and result registers.
// ----------------------------------------------------------------------------
module sfla_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sfla_pkg::sfla_cmd_t                   cmd,
    input  logic [1:0]                            action,
    input  logic signed [sfla_pkg::VALUE_W-1:0]   value,
    input  logic [sfla_pkg::SLOT_W-1:0]           slot,
    output logic [sfla_pkg::SLOT_W-1:0]           assigned_slot,
    output logic signed [sfla_pkg::VALUE_W-1:0]   read_value,
    output logic [1:0]                            status
);

    // Memories
    logic [sfla_pkg::VALUE_W-1:0] slot_mem  [sfla_pkg::SLOT_COUNT];
    logic [sfla_pkg::SLOT_W-1:0]  stack_mem [sfla_pkg::FREE_STACK_DEPTH];

    // Counters
    logic [sfla_pkg::HW_W-1:0] high_water_reg, high_water_next;
    logic [sfla_pkg::FC_W-1:0] free_count_reg, free_count_next;

    // Latched request and registered memory reads
    logic [1:0]                   action_reg;
    logic [sfla_pkg::VALUE_W-1:0] value_reg;
    logic [sfla_pkg::SLOT_W-1:0]  slot_reg;
    logic [sfla_pkg::VALUE_W-1:0] rd_value_reg;
    logic [sfla_pkg::SLOT_W-1:0]  rd_top_reg;

    // Result registers
    logic [sfla_pkg::SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic [sfla_pkg::VALUE_W-1:0] res_value_reg, res_value_next;
    logic [1:0]                   res_status_reg, res_status_next;

    // Write ports
    logic                         val_wr_en;
    logic [sfla_pkg::SLOT_W-1:0]  val_wr_addr;
    logic [sfla_pkg::VALUE_W-1:0] val_wr_data;
    logic                         stk_wr_en;

    logic [sfla_pkg::FC_W-1:0]    fc_dec;
    logic [sfla_pkg::STK_AW-1:0]  top_addr;

    assign fc_dec   = free_count_reg - sfla_pkg::FC_W'(1);
    assign top_addr = fc_dec[sfla_pkg::STK_AW-1:0];

    // Request latch and memory reads at accept
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg   <= action;
            value_reg    <= value;
            slot_reg     <= slot;
            rd_value_reg <= slot_mem[slot];
            rd_top_reg   <= stack_mem[top_addr];
        end
    end

    // Memory writes in the execute cycle
    always_ff @(posedge clk)
    begin
        if (val_wr_en)
        begin
            slot_mem[val_wr_addr] <= val_wr_data;
        end
        if (stk_wr_en)
        begin
            stack_mem[free_count_reg[sfla_pkg::STK_AW-1:0]] <= slot_reg;
        end
    end

    // Counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_water_reg <= '0;
            free_count_reg <= '0;
        end
        else
        begin
            high_water_reg <= high_water_next;
            free_count_reg <= free_count_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        res_slot_reg   <= res_slot_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

    // Request evaluation
    always_comb
    begin
        logic                         r_en;
        logic [sfla_pkg::SLOT_W-1:0]  r_slot;
        logic [sfla_pkg::VALUE_W-1:0] r_val;
        logic [1:0]                   r_st;
        r_en            = cmd.exec;
        r_slot          = '0;
        r_val           = '0;
        r_st            = sfla_pkg::ST_OK;
        val_wr_en       = 1'b0;
        val_wr_addr     = slot_reg;
        val_wr_data     = value_reg;
        stk_wr_en       = 1'b0;
        high_water_next = high_water_reg;
        free_count_next = free_count_reg;

        unique case (action_reg)
            sfla_pkg::ACT_PUSH:
            begin
                if (free_count_reg != '0)
                begin
                    // reuse the most recently freed slot
                    r_slot          = rd_top_reg;
                    val_wr_en       = r_en;
                    val_wr_addr     = rd_top_reg;
                    if (r_en)
                        free_count_next = fc_dec;
                end
                else if (high_water_reg >= sfla_pkg::SLOT_COUNT_HW)
                begin
                    r_val = sfla_pkg::NULL_MARK;
                    r_st  = sfla_pkg::ST_FULL;
                end
                else
                begin
                    // take the next never-used slot
                    r_slot      = high_water_reg[sfla_pkg::SLOT_W-1:0];
                    val_wr_en   = r_en;
                    val_wr_addr = high_water_reg[sfla_pkg::SLOT_W-1:0];
                    if (r_en)
                        high_water_next = high_water_reg + sfla_pkg::HW_W'(1);
                end
            end
            sfla_pkg::ACT_POP, sfla_pkg::ACT_GET:
            begin
                if (sfla_pkg::HW_W'(slot_reg) >= high_water_reg)
                begin
                    r_val = sfla_pkg::NULL_MARK;
                    r_st  = sfla_pkg::ST_RANGE;
                end
                else if (action_reg == sfla_pkg::ACT_GET)
                begin
                    r_val = rd_value_reg;
                end
                else if (free_count_reg >= sfla_pkg::STACK_DEPTH_FC)
                begin
                    r_val = sfla_pkg::NULL_MARK;
                    r_st  = sfla_pkg::ST_STACK;
                end
                else
                begin
                    // free the slot: push index, mark value null
                    r_val       = rd_value_reg;
                    stk_wr_en   = r_en;
                    val_wr_en   = r_en;
                    val_wr_addr = slot_reg;
                    val_wr_data = sfla_pkg::NULL_MARK;
                    if (r_en)
                        free_count_next = free_count_reg + sfla_pkg::FC_W'(1);
                end
            end
            default:
            begin
                r_val = sfla_pkg::NULL_MARK;
                r_st  = sfla_pkg::ST_RANGE;
            end
        endcase

        res_slot_next   = r_en ? r_slot : res_slot_reg;
        res_value_next  = r_en ? r_val  : res_value_reg;
        res_status_next = r_en ? r_st   : res_status_reg;
    end

    assign assigned_slot = res_slot_reg;
    assign read_value    = res_value_reg;
    assign status        = res_status_reg;

endmodule

@@ hdl/slot_table_free_list_allocator_core.sv @@
// ----------------------------------------------------------------------------
// slot_table_free_list_allocator_core
// Fixed-depth slot table with a LIFO free stack of released slot indices.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid / in_stall) carries action, value and slot.
//   Push stores value in the last freed slot, else the next unused one,
//   and returns the slot in assigned_slot. Pop returns a slot's value,
//   nulls it and frees its index. Get returns a slot's value.
//   Result channel (out_valid / out_stall) carries assigned_slot,
//   read_value and status; one result beat per request.
//   The request is latched and both memories are read in the accept
//   cycle, then the memory writes, counter updates and result register
//   load happen in the execute cycle. A new request is not taken until
//   the previous one has finished its execute cycle.
//   The result register frees the request side: a new request is taken
//   while a result waits. If the receiver stalls, the next request holds in
//   its execute cycle until the result register is taken.
//   Reset clears the high-water mark, free count and result valid flag; the
//   memories need no clearing, since no unwritten entry's value is used.
// ----------------------------------------------------------------------------
module slot_table_free_list_allocator_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            action,
    input  logic signed [sfla_pkg::VALUE_W-1:0]   value,
    input  logic [sfla_pkg::SLOT_W-1:0]           slot,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [sfla_pkg::SLOT_W-1:0]           assigned_slot,
    output logic signed [sfla_pkg::VALUE_W-1:0]   read_value,
    output logic [1:0]                            status
);

    sfla_pkg::sfla_cmd_t cmd;

    // Sequencer
    sfla_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Memories, counters and result registers
    sfla_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .action        (action),
        .value         (value),
        .slot          (slot),
        .assigned_slot (assigned_slot),
        .read_value    (read_value),
        .status        (status)
    );

endmodule
